FILE: src/mrf_pkg.sv
// Shared types and constants for the Modbus RTU request framer.
// Used by mrf_front, mrf_queue, mrf_back and modbus_rtu_request_framer.
// No dependencies.
package mrf_pkg;

    // Request item modes
    localparam logic [3:0] MODE_RD_COILS    = 4'd0;
    localparam logic [3:0] MODE_RD_DISCRETE = 4'd1;
    localparam logic [3:0] MODE_RD_HOLDING  = 4'd2;
    localparam logic [3:0] MODE_RD_INPUT    = 4'd3;
    localparam logic [3:0] MODE_WR_COIL     = 4'd4;
    localparam logic [3:0] MODE_WR_REG      = 4'd5;
    localparam logic [3:0] MODE_WR_COILS    = 4'd6;
    localparam logic [3:0] MODE_WR_REGS     = 4'd7;
    localparam logic [3:0] MODE_DATA        = 4'd8;

    // Quantity limits for multiple writes
    localparam int MAX_COILS     = 1968;
    localparam int MAX_REGISTERS = 123;

    // Job queue between front and back end
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_QTY = 2'd1,
        STATUS_SEQ = 2'd2
    } status_t;

    // One unit of work for the back end: up to seven payload bytes, optional
    // CRC restart before the first byte and CRC trailer after the last one,
    // or a single error result.
    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [2:0]      count;
        logic            crc_start;
        logic            crc_end;
        logic            is_error;
        status_t         status;
    } job_t;

    // Queue fill flags
    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

endpackage

FILE: src/mrf_front.sv
// Front end: accepts request and data items, tracks multiple-write sequencing
// and coil packing, and turns each item into a job for the back end.
// Depends on mrf_pkg.
module mrf_front
    import mrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [3:0]  mode,
    input  logic [15:0] address,
    input  logic [15:0] quantity_or_value,
    input  logic [15:0] data_word,
    output logic        push,
    output job_t        job
);

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_COILS = 2'd1,
        PEND_REGS  = 2'd2
    } pend_t;

    pend_t       pend_reg, pend_next;
    logic [10:0] remain_reg, remain_next;
    logic [7:0]  pack_reg, pack_next;
    logic [2:0]  bitpos_reg, bitpos_next;
    logic [7:0]  slave_id_reg;

    logic        accept;
    logic [15:0] qv_sent;
    logic [15:0] coil_round;
    logic [10:0] remain_dec;
    logic [7:0]  pack_set;

    function automatic logic [7:0] fcode_of(input logic [3:0] m);
        logic [7:0] f;
        unique case (m)
            MODE_RD_COILS:    f = 8'h01;
            MODE_RD_DISCRETE: f = 8'h02;
            MODE_RD_HOLDING:  f = 8'h03;
            MODE_RD_INPUT:    f = 8'h04;
            MODE_WR_COIL:     f = 8'h05;
            MODE_WR_REG:      f = 8'h06;
            MODE_WR_COILS:    f = 8'h0F;
            MODE_WR_REGS:     f = 8'h10;
            default:          f = 8'h00;
        endcase
        return f;
    endfunction

    assign accept     = in_valid && !in_stall;
    assign qv_sent    = (mode == MODE_WR_COIL)
                        ? ((quantity_or_value != 16'd0) ? 16'hFF00 : 16'h0000)
                        : quantity_or_value;
    assign coil_round = quantity_or_value + 16'd7;
    assign remain_dec = remain_reg - 11'd1;
    assign pack_set   = pack_reg | (8'(data_word[0]) << bitpos_reg);

    // Item classification and job build
    always_comb
    begin
        push          = 1'b0;
        job           = '0;
        job.status    = STATUS_OK;
        pend_next     = pend_reg;
        remain_next   = remain_reg;
        pack_next     = pack_reg;
        bitpos_next   = bitpos_reg;

        if (mode <= MODE_WR_REGS)
        begin
            job.bytes[0]  = slave_id_reg;
            job.bytes[1]  = fcode_of(mode);
            job.bytes[2]  = address[15:8];
            job.bytes[3]  = address[7:0];
            job.bytes[4]  = qv_sent[15:8];
            job.bytes[5]  = qv_sent[7:0];
            job.crc_start = 1'b1;
            priority if (pend_reg != PEND_NONE)
            begin
                job.is_error = 1'b1;
                job.status   = STATUS_SEQ;
            end
            else if (mode == MODE_WR_COILS &&
                     (quantity_or_value == 16'd0 ||
                      quantity_or_value > 16'(MAX_COILS)))
            begin
                job.is_error = 1'b1;
                job.status   = STATUS_QTY;
            end
            else if (mode == MODE_WR_REGS &&
                     (quantity_or_value == 16'd0 ||
                      quantity_or_value > 16'(MAX_REGISTERS)))
            begin
                job.is_error = 1'b1;
                job.status   = STATUS_QTY;
            end
            else if (mode == MODE_WR_COILS || mode == MODE_WR_REGS)
            begin
                job.count    = 3'd7;
                job.bytes[6] = (mode == MODE_WR_COILS) ? coil_round[10:3]
                                                       : {quantity_or_value[6:0], 1'b0};
                pend_next    = (mode == MODE_WR_COILS) ? PEND_COILS : PEND_REGS;
                remain_next  = quantity_or_value[10:0];
                pack_next    = 8'd0;
                bitpos_next  = 3'd0;
            end
            else
            begin
                job.count   = 3'd6;
                job.crc_end = 1'b1;
            end
            push = accept;
        end
        else if (mode == MODE_DATA && pend_reg != PEND_NONE && remain_reg != 11'd0)
        begin
            remain_next = remain_dec;
            job.crc_end = (remain_dec == 11'd0);
            if (pend_reg == PEND_COILS)
            begin
                bitpos_next = bitpos_reg + 3'd1;
                pack_next   = pack_set;
                if (bitpos_reg == 3'd7 || remain_dec == 11'd0)
                begin
                    job.count    = 3'd1;
                    job.bytes[0] = pack_set;
                    pack_next    = 8'd0;
                    bitpos_next  = 3'd0;
                end
            end
            else
            begin
                job.count    = 3'd2;
                job.bytes[0] = data_word[15:8];
                job.bytes[1] = data_word[7:0];
            end
            if (remain_dec == 11'd0)
            begin
                pend_next = PEND_NONE;
            end
            // A coil that completes no byte produces nothing
            push = accept && (job.count != 3'd0);
        end
        else
        begin
            job.is_error = 1'b1;
            job.status   = STATUS_SEQ;
            push         = accept;
        end

        // Any error drops the sequence state
        if (job.is_error)
        begin
            pend_next   = PEND_NONE;
            remain_next = 11'd0;
            pack_next   = 8'd0;
            bitpos_next = 3'd0;
        end
    end

    // Sequence state and slave address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= PEND_NONE;
            remain_reg   <= 11'd0;
            pack_reg     <= 8'd0;
            bitpos_reg   <= 3'd0;
            slave_id_reg <= 8'd1;
        end
        else
        begin
            if (accept)
            begin
                pend_reg   <= pend_next;
                remain_reg <= remain_next;
                pack_reg   <= pack_next;
                bitpos_reg <= bitpos_next;
            end
            if (cfg_valid)
            begin
                slave_id_reg <= cfg_data;
            end
        end
    end

endmodule

FILE: src/mrf_queue.sv
// Short job queue between the front and back ends, show-ahead read.
// Depends on mrf_pkg.
module mrf_queue
    import mrf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  job_t     push_job,
    input  logic     pop,
    output job_t     head,
    output q_flags_t flags
);

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              do_push, do_pop;

    assign flags.full  = (cnt_reg == (QPTR_W + 1)'(QDEPTH));
    assign flags.empty = (cnt_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign head        = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/mrf_back.sv
// Back end: walks the head job one byte per cycle while out_stall is low, runs
// CRC-16/MODBUS, appends the CRC trailer where asked; holds the output register.
// Depends on mrf_pkg.
module mrf_back
    import mrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  q_flags_t   flags,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic       frame_last,
    output logic [1:0] status
);

    logic [15:0] crc_reg, crc_next;
    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    status_t     status_reg;

    logic        fire, done;
    logic [7:0]  byte_sel;
    logic        last_sel;
    logic [15:0] crc_base;

    // Reflected CRC-16, polynomial 0xA001, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    assign fire     = !flags.empty && (!out_valid_reg || !out_stall);
    assign pop      = fire && done;
    assign crc_base = (head.crc_start && idx_reg == 3'd0) ? 16'hFFFF : crc_reg;

    // Byte selection for the current step of the head job
    always_comb
    begin
        byte_sel = 8'd0;
        last_sel = 1'b0;
        done     = 1'b0;
        crc_next = crc_reg;
        if (head.is_error)
        begin
            last_sel = 1'b1;
            done     = 1'b1;
            crc_next = 16'hFFFF;
        end
        else if (idx_reg < head.count)
        begin
            byte_sel = head.bytes[idx_reg];
            crc_next = crc_byte(crc_base, byte_sel);
            done     = ({1'b0, idx_reg} + 4'd1 == {1'b0, head.count}) && !head.crc_end;
        end
        else if (idx_reg == head.count)
        begin
            byte_sel = crc_reg[7:0];
            done     = !head.crc_end;
        end
        else
        begin
            byte_sel = crc_reg[15:8];
            last_sel = 1'b1;
            done     = 1'b1;
            crc_next = 16'hFFFF;
        end
        idx_next = done ? 3'd0 : idx_reg + 3'd1;
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= 16'hFFFF;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                crc_reg       <= crc_next;
                idx_reg       <= idx_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg   <= byte_sel;
            last_reg   <= last_sel;
            status_reg <= head.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign frame_last = last_reg;
    assign status     = status_reg;

endmodule

FILE: src/modbus_rtu_request_framer.sv
// Modbus RTU request framer: each accepted item leaves as zero to eight frame
// bytes, one byte per cycle while out_stall is low. A read or single write
// gives 8 bytes, a multiple-write header 7, a data item 0 to 4 (2 for a
// register, 1 when coil packing completes a byte and none when it does not,
// plus 2 for the CRC trailer on the last element), an error 1. The byte
// sequencer in the back end, which folds each byte into the CRC as it leaves,
// emits these bytes. With the queue empty and the output free, an accepted
// item is first written into the queue and its first byte is then taken into
// the output register. A 4-job queue sits between the input side and that
// sequencer, so in_stall rises only when the queue is full, and the output
// register takes the next byte at the same edge the held one leaves, so bytes stream back to back.
// Depends on mrf_pkg, mrf_front, mrf_queue, mrf_back.
module modbus_rtu_request_framer
    import mrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  mode,
    input  logic [15:0] address,
    input  logic [15:0] quantity_or_value,
    input  logic [15:0] data_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        frame_last,
    output logic [1:0]  status
);

    logic     push, pop;
    job_t     push_job, head;
    q_flags_t flags;

    assign cfg_ready = 1'b1;
    assign in_stall  = flags.full;

    mrf_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .address           (address),
        .quantity_or_value (quantity_or_value),
        .data_word         (data_word),
        .push              (push),
        .job               (push_job)
    );

    mrf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .flags    (flags)
    );

    mrf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .flags      (flags),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .status     (status)
    );

    // Error results carry a zero byte and close the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> frame_byte == 8'd0 && frame_last)
        else $error("error result with nonzero byte or open frame");

    // Status code 3 is never produced
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

    // Queue cannot be full and empty at once
    assert property (@(posedge clk) disable iff (!rst_n)
        !(flags.full && flags.empty))
        else $error("queue flags inconsistent");

    // The back end never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !flags.empty)
        else $error("pop from empty queue");

endmodule
